>>> rtl/cwh_pkg.sv
// Shared types and constants of the cylindrical weighted histogram.
`timescale 1ns / 1ps
`default_nettype none

package cwh_pkg;

   localparam logic [1:0] OP_ACCUM = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [2:0] ST_ACCUM = 3'd0;
   localparam logic [2:0] ST_SPACE = 3'd1;
   localparam logic [2:0] ST_INDEX = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_CLEAR = 3'd4;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_LIMIT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_LOW   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_HIGH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_SCALE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_SCALE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST        = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST         = 3'd6;

   localparam logic [31:0] RST_RADIUS_LIMIT = 32'd6554;
   localparam logic [31:0] RST_HEIGHT_LOW   = 32'hFFFF0000;
   localparam logic [31:0] RST_HEIGHT_HIGH  = 32'h00010000;
   localparam logic [31:0] RST_RADIUS_SCALE = 32'd41943040;
   localparam logic [31:0] RST_HEIGHT_SCALE = 32'd2097152;

   localparam logic [2:0] MUL_XX = 3'd0;
   localparam logic [2:0] MUL_YY = 3'd1;
   localparam logic [2:0] MUL_RS = 3'd2;
   localparam logic [2:0] MUL_ZS = 3'd3;
   localparam logic [2:0] MUL_MA = 3'd4;
   localparam logic [2:0] MUL_MB = 3'd5;
   localparam logic [2:0] MUL_LO = 3'd6;
   localparam logic [2:0] MUL_HI = 3'd7;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [31:0]        mass;
      logic signed [31:0] value_a;
      logic signed [31:0] value_b;
      logic [5:0]         read_radius_bin;
      logic [5:0]         read_height_bin;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [63:0]        sum_mass;
      logic signed [63:0] sum_mass_a;
      logic signed [63:0] sum_mass_b;
      logic signed [63:0] sum_mass_ab;
   } rsp_type;

   typedef struct packed {
      logic       ready;
      logic [2:0] mul_sel;
      logic       n_load;
      logic       n_add;
      logic       sqrt_step;
      logic       cap_ir;
      logic       cap_iz;
      logic       cap_ma;
      logic       cap_mb;
      logic       cap_lob;
      logic       cap_ab;
      logic       mem_wr;
      logic       clr_step;
      logic       rsp_load;
      logic [2:0] code;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       index_fail;
      logic       space_fail;
      logic       bin_fail;
      logic       sqrt_last;
      logic       clr_last;
      logic       rsp_free;
   } sts_type;

endpackage

`default_nettype wire

>>> rtl/cylindrical_weighted_histogram.sv
// Top level of the cylindrical weighted histogram.
//
//   Channel  Ports                                  Direction  Beat
//   request  req_valid, req_stall, req_data          in         one operation
//   response rsp_valid, rsp_stall, rsp_data          out        one status and four sums
//   control  csr_we, csr_index, csr_wdata            in         one register write
//
// An accumulate runs through the 32-step square root and the shared multiplier.
// A read passes through the registered read of the bin memories before its response is loaded.
// A clear and the pass after reset each sweep all RADIUS_BINS*HEIGHT_BINS bins, one bin per cycle.
// A finished beat waits in the response register while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none

module cylindrical_weighted_histogram #(
   parameter int RADIUS_BINS = 64,
   parameter int HEIGHT_BINS = 64
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            csr_we,
   input  wire [cwh_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [31:0]                     csr_wdata,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  cwh_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output cwh_pkg::rsp_type               rsp_data
);

   cwh_pkg::cmd_type cmd;
   cwh_pkg::sts_type sts;

   assign req_stall = !cmd.ready;

   cwh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   cwh_dp #(
      .RADIUS_BINS (RADIUS_BINS),
      .HEIGHT_BINS (HEIGHT_BINS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

`default_nettype wire

>>> rtl/cwh_ctrl.sv
// Sequencing state machine of the cylindrical weighted histogram.
`timescale 1ns / 1ps
`default_nettype none

module cwh_ctrl (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   input  cwh_pkg::sts_type sts,
   output cwh_pkg::cmd_type cmd
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_CHECK = 5'd1;
   localparam logic [4:0] S_SQY   = 5'd2;
   localparam logic [4:0] S_SQS   = 5'd3;
   localparam logic [4:0] S_SQRT  = 5'd4;
   localparam logic [4:0] S_WIN   = 5'd5;
   localparam logic [4:0] S_MZ    = 5'd6;
   localparam logic [4:0] S_MMA   = 5'd7;
   localparam logic [4:0] S_MMB   = 5'd8;
   localparam logic [4:0] S_MLO   = 5'd9;
   localparam logic [4:0] S_MHI   = 5'd10;
   localparam logic [4:0] S_AB    = 5'd11;
   localparam logic [4:0] S_WB    = 5'd12;
   localparam logic [4:0] S_RD0   = 5'd13;
   localparam logic [4:0] S_CLR   = 5'd14;
   localparam logic [4:0] S_DONE  = 5'd15;

   logic [4:0] state_ff, state_in;
   logic [2:0] code_ff, code_in;
   logic       report_ff, report_in;

   always_comb begin
      cmd       = '0;
      cmd.code  = code_ff;
      state_in  = state_ff;
      code_in   = code_ff;
      report_in = report_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.ready = 1'b1;
            if (req_valid) begin
               case (sts.op)
                  cwh_pkg::OP_ACCUM: state_in = S_CHECK;
                  cwh_pkg::OP_READ:  state_in = S_RD0;
                  cwh_pkg::OP_CLEAR: begin
                     state_in  = S_CLR;
                     report_in = 1'b1;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_CHECK: begin
            if (sts.index_fail) begin
               code_in  = cwh_pkg::ST_INDEX;
               state_in = S_DONE;
            end else begin
               cmd.mul_sel = cwh_pkg::MUL_XX;
               state_in    = S_SQY;
            end
         end
         S_SQY: begin
            cmd.mul_sel = cwh_pkg::MUL_YY;
            cmd.n_load  = 1'b1;
            state_in    = S_SQS;
         end
         S_SQS: begin
            cmd.n_add = 1'b1;
            state_in  = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (sts.sqrt_last) begin
               state_in = S_WIN;
            end
         end
         S_WIN: begin
            if (sts.space_fail) begin
               code_in  = cwh_pkg::ST_SPACE;
               state_in = S_DONE;
            end else begin
               cmd.mul_sel = cwh_pkg::MUL_RS;
               state_in    = S_MZ;
            end
         end
         S_MZ: begin
            cmd.mul_sel = cwh_pkg::MUL_ZS;
            cmd.cap_ir  = 1'b1;
            state_in    = S_MMA;
         end
         S_MMA: begin
            cmd.mul_sel = cwh_pkg::MUL_MA;
            cmd.cap_iz  = 1'b1;
            state_in    = S_MMB;
         end
         S_MMB: begin
            cmd.mul_sel = cwh_pkg::MUL_MB;
            cmd.cap_ma  = 1'b1;
            if (sts.bin_fail) begin
               code_in  = cwh_pkg::ST_SPACE;
               state_in = S_DONE;
            end else begin
               state_in = S_MLO;
            end
         end
         S_MLO: begin
            cmd.mul_sel = cwh_pkg::MUL_LO;
            cmd.cap_mb  = 1'b1;
            state_in    = S_MHI;
         end
         S_MHI: begin
            cmd.mul_sel = cwh_pkg::MUL_HI;
            cmd.cap_lob = 1'b1;
            state_in    = S_AB;
         end
         S_AB: begin
            cmd.cap_ab = 1'b1;
            state_in   = S_WB;
         end
         S_WB: begin
            cmd.mem_wr = 1'b1;
            code_in    = cwh_pkg::ST_ACCUM;
            state_in   = S_DONE;
         end
         S_RD0: begin
            code_in  = cwh_pkg::ST_READ;
            state_in = S_DONE;
         end
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               if (report_ff) begin
                  code_in  = cwh_pkg::ST_CLEAR;
                  state_in = S_DONE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLR;
         code_ff   <= cwh_pkg::ST_ACCUM;
         report_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         code_ff   <= code_in;
         report_ff <= report_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/cwh_dp.sv
// Datapath of the cylindrical weighted histogram: registers, multiplier, root unit, bin memories.
`timescale 1ns / 1ps
`default_nettype none

module cwh_dp #(
   parameter int RADIUS_BINS = 64,
   parameter int HEIGHT_BINS = 64
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            csr_we,
   input  wire [cwh_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [31:0]                     csr_wdata,
   input  wire                            req_valid,
   input  cwh_pkg::req_type               req_data,
   input  wire                            rsp_stall,
   output logic                           rsp_valid,
   output cwh_pkg::rsp_type               rsp_data,
   input  cwh_pkg::cmd_type               cmd,
   output cwh_pkg::sts_type               sts
);

   localparam int BIN_COUNT = RADIUS_BINS * HEIGHT_BINS;
   localparam int ADDR_W    = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   function automatic logic [63:0] floor_s(input logic [63:0] q, input logic rem,
                                           input logic neg);
      return neg ? (~(q + 64'(rem)) + 64'd1) : q;
   endfunction

   function automatic logic [63:0] sat_u(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

   function automatic logic [63:0] sat_s(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if ((a[63] == b[63]) && (s[63] != a[63])) begin
         return b[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
      return s;
   endfunction

   logic [31:0]        radius_limit_ff, radius_limit_in;
   logic signed [31:0] height_low_ff, height_low_in;
   logic signed [31:0] height_high_ff, height_high_in;
   logic [31:0]        radius_scale_ff, radius_scale_in;
   logic [31:0]        height_scale_ff, height_scale_in;
   logic [31:0]        first_ff, first_in;
   logic [31:0]        last_ff, last_in;

   cwh_pkg::req_type   in_ff, in_in;
   logic [31:0]        counter_ff, counter_in;
   logic [31:0]        idx_ff, idx_in;
   logic [63:0]        prod_ff, prod_in;
   logic [63:0]        n_ff, n_in;
   logic [63:0]        root_ff, root_in;
   logic [63:0]        bit_ff, bit_in;
   logic [31:0]        ir_ff, ir_in;
   logic [31:0]        iz_ff, iz_in;
   logic [63:0]        ma_ff, ma_in;
   logic [63:0]        mb_ff, mb_in;
   logic [63:0]        lob_ff, lob_in;
   logic [63:0]        sa_ff, sa_in;
   logic [63:0]        sb_ff, sb_in;
   logic [63:0]        sab_ff, sab_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   cwh_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic [63:0] mem_m  [BIN_COUNT];
   logic [63:0] mem_a  [BIN_COUNT];
   logic [63:0] mem_b  [BIN_COUNT];
   logic [63:0] mem_ab [BIN_COUNT];
   logic [63:0] rd_m_ff, rd_a_ff, rd_b_ff, rd_ab_ff;

   logic               accept;
   logic [31:0]        mag_x, mag_y, mag_a, mag_b, opa, opb, r_val, zoff;
   logic signed [32:0] zoff_w;
   logic               neg_a, neg_b, sqrt_ge, clr_last, rd_in_grid, mem_we;
   logic [63:0]        sqrt_t, ab_q, wr_m, wr_a, wr_b, wr_ab;
   logic [31:0]        cell_w, user_w, rbin, hbin;
   logic [ADDR_W-1:0]  acc_addr, user_addr, rd_addr, wr_addr;

   assign accept  = req_valid & cmd.ready;
   assign mag_x   = mag32(in_ff.pos_x);
   assign mag_y   = mag32(in_ff.pos_y);
   assign mag_a   = mag32(in_ff.value_a);
   assign mag_b   = mag32(in_ff.value_b);
   assign neg_a   = in_ff.value_a[31];
   assign neg_b   = in_ff.value_b[31];
   assign r_val   = root_ff[31:0];
   assign zoff_w  = {in_ff.pos_z[31], in_ff.pos_z} - {height_low_ff[31], height_low_ff};
   assign zoff    = zoff_w[31:0];
   assign sqrt_t  = root_ff + bit_ff;
   assign sqrt_ge = n_ff >= sqrt_t;
   assign clr_last = clr_addr_ff == ADDR_W'(BIN_COUNT - 1);

   assign cell_w   = iz_ff * 32'(RADIUS_BINS) + ir_ff;
   assign acc_addr = cell_w[ADDR_W-1:0];
   assign rbin     = 32'(in_ff.read_radius_bin);
   assign hbin     = 32'(in_ff.read_height_bin);
   assign rd_in_grid = (rbin < 32'(RADIUS_BINS)) && (hbin < 32'(HEIGHT_BINS));
   assign user_w    = hbin * 32'(RADIUS_BINS) + rbin;
   assign user_addr = rd_in_grid ? user_w[ADDR_W-1:0] : '0;
   assign rd_addr   = (in_ff.op == cwh_pkg::OP_READ) ? user_addr : acc_addr;
   assign wr_addr   = cmd.clr_step ? clr_addr_ff : acc_addr;
   assign mem_we    = cmd.mem_wr | cmd.clr_step;

   assign wr_m  = cmd.clr_step ? 64'd0 : sat_u(rd_m_ff, 64'(in_ff.mass));
   assign wr_a  = cmd.clr_step ? 64'd0 : sat_s(rd_a_ff, sa_ff);
   assign wr_b  = cmd.clr_step ? 64'd0 : sat_s(rd_b_ff, sb_ff);
   assign wr_ab = cmd.clr_step ? 64'd0 : sat_s(rd_ab_ff, sab_ff);
   assign ab_q  = prod_ff + {32'd0, lob_ff[63:32]};

   always_comb begin
      case (cmd.mul_sel)
         cwh_pkg::MUL_XX: begin opa = mag_x;           opb = mag_x;           end
         cwh_pkg::MUL_YY: begin opa = mag_y;           opb = mag_y;           end
         cwh_pkg::MUL_RS: begin opa = r_val;           opb = radius_scale_ff; end
         cwh_pkg::MUL_ZS: begin opa = zoff;            opb = height_scale_ff; end
         cwh_pkg::MUL_MA: begin opa = in_ff.mass;      opb = mag_a;           end
         cwh_pkg::MUL_MB: begin opa = in_ff.mass;      opb = mag_b;           end
         cwh_pkg::MUL_LO: begin opa = ma_ff[31:0];     opb = mag_b;           end
         cwh_pkg::MUL_HI: begin opa = ma_ff[63:32];    opb = mag_b;           end
         default:         begin opa = '0;              opb = '0;              end
      endcase
      prod_in = 64'(opa) * 64'(opb);
   end

   always_comb begin
      radius_limit_in = radius_limit_ff;
      height_low_in   = height_low_ff;
      height_high_in  = height_high_ff;
      radius_scale_in = radius_scale_ff;
      height_scale_in = height_scale_ff;
      first_in        = first_ff;
      last_in         = last_ff;
      if (csr_we) begin
         case (csr_index)
            cwh_pkg::CSR_RADIUS_LIMIT: radius_limit_in = csr_wdata;
            cwh_pkg::CSR_HEIGHT_LOW:   height_low_in   = csr_wdata;
            cwh_pkg::CSR_HEIGHT_HIGH:  height_high_in  = csr_wdata;
            cwh_pkg::CSR_RADIUS_SCALE: radius_scale_in = csr_wdata;
            cwh_pkg::CSR_HEIGHT_SCALE: height_scale_in = csr_wdata;
            cwh_pkg::CSR_FIRST:        first_in        = csr_wdata;
            cwh_pkg::CSR_LAST:         last_in         = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      in_in      = accept ? req_data : in_ff;
      idx_in     = idx_ff;
      counter_in = counter_ff;
      if (accept && (req_data.op == cwh_pkg::OP_ACCUM)) begin
         idx_in     = counter_ff;
         counter_in = counter_ff + 32'd1;
      end else if (accept && (req_data.op == cwh_pkg::OP_CLEAR)) begin
         counter_in = '0;
      end

      n_in    = n_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      if (cmd.n_load) begin
         n_in = prod_ff;
      end else if (cmd.n_add) begin
         n_in    = n_ff + prod_ff;
         root_in = '0;
         bit_in  = 64'd1 << 62;
      end else if (cmd.sqrt_step) begin
         if (sqrt_ge) begin
            n_in    = n_ff - sqrt_t;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end

      ir_in  = cmd.cap_ir  ? prod_ff[63:32] : ir_ff;
      iz_in  = cmd.cap_iz  ? prod_ff[63:32] : iz_ff;
      ma_in  = cmd.cap_ma  ? prod_ff : ma_ff;
      mb_in  = cmd.cap_mb  ? prod_ff : mb_ff;
      lob_in = cmd.cap_lob ? prod_ff : lob_ff;
      sa_in  = sa_ff;
      sb_in  = sb_ff;
      sab_in = sab_ff;
      if (cmd.cap_ab) begin
         sa_in  = floor_s({16'd0, ma_ff[63:16]}, ma_ff[15:0] != 16'd0, neg_a);
         sb_in  = floor_s({16'd0, mb_ff[63:16]}, mb_ff[15:0] != 16'd0, neg_b);
         sab_in = floor_s(ab_q, lob_ff[31:0] != 32'd0, neg_a ^ neg_b);
      end

      clr_addr_in = clr_addr_ff;
      if (cmd.clr_step) begin
         clr_addr_in = clr_last ? '0 : clr_addr_ff + ADDR_W'(1);
      end

      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      if (cmd.rsp_load) begin
         rsp_valid_in       = 1'b1;
         rsp_data_in.status = cmd.code;
         if ((cmd.code == cwh_pkg::ST_READ) && rd_in_grid) begin
            rsp_data_in.sum_mass    = rd_m_ff;
            rsp_data_in.sum_mass_a  = rd_a_ff;
            rsp_data_in.sum_mass_b  = rd_b_ff;
            rsp_data_in.sum_mass_ab = rd_ab_ff;
         end else begin
            rsp_data_in.sum_mass    = '0;
            rsp_data_in.sum_mass_a  = '0;
            rsp_data_in.sum_mass_b  = '0;
            rsp_data_in.sum_mass_ab = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_limit_ff <= cwh_pkg::RST_RADIUS_LIMIT;
         height_low_ff   <= cwh_pkg::RST_HEIGHT_LOW;
         height_high_ff  <= cwh_pkg::RST_HEIGHT_HIGH;
         radius_scale_ff <= cwh_pkg::RST_RADIUS_SCALE;
         height_scale_ff <= cwh_pkg::RST_HEIGHT_SCALE;
         first_ff        <= '0;
         last_ff         <= '0;
         counter_ff      <= '0;
         clr_addr_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         radius_limit_ff <= radius_limit_in;
         height_low_ff   <= height_low_in;
         height_high_ff  <= height_high_in;
         radius_scale_ff <= radius_scale_in;
         height_scale_ff <= height_scale_in;
         first_ff        <= first_in;
         last_ff         <= last_in;
         counter_ff      <= counter_in;
         clr_addr_ff     <= clr_addr_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff       <= in_in;
      idx_ff      <= idx_in;
      prod_ff     <= prod_in;
      n_ff        <= n_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      ir_ff       <= ir_in;
      iz_ff       <= iz_in;
      ma_ff       <= ma_in;
      mb_ff       <= mb_in;
      lob_ff      <= lob_in;
      sa_ff       <= sa_in;
      sb_ff       <= sb_in;
      sab_ff      <= sab_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_m[wr_addr]  <= wr_m;
         mem_a[wr_addr]  <= wr_a;
         mem_b[wr_addr]  <= wr_b;
         mem_ab[wr_addr] <= wr_ab;
      end
      rd_m_ff  <= mem_m[rd_addr];
      rd_a_ff  <= mem_a[rd_addr];
      rd_b_ff  <= mem_b[rd_addr];
      rd_ab_ff <= mem_ab[rd_addr];
   end

   assign sts.op         = req_data.op;
   assign sts.index_fail = (idx_ff < first_ff) || ((last_ff != 32'd0) && (idx_ff > last_ff));
   assign sts.space_fail = (in_ff.pos_z < height_low_ff) || (in_ff.pos_z >= height_high_ff)
                           || (r_val >= radius_limit_ff);
   assign sts.bin_fail   = (ir_ff >= 32'(RADIUS_BINS)) || (iz_ff >= 32'(HEIGHT_BINS));
   assign sts.sqrt_last  = bit_ff[0];
   assign sts.clr_last   = clr_last;
   assign sts.rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   ap_clr_wrap: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_step && clr_last |=> clr_addr_ff == '0)
      else $error("Clear sweep did not wrap to the first bin.");

   ap_root_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.sqrt_step && bit_ff[0] |=> root_ff[63:32] == 32'd0)
      else $error("Square root result exceeds 32 bits.");

   ap_wr_in_grid: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_wr |-> !sts.bin_fail)
      else $error("Bin update outside the grid.");

   ap_sums_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status != cwh_pkg::ST_READ) |->
         (rsp_data_ff.sum_mass == 64'd0) && (rsp_data_ff.sum_mass_a == 64'sd0) &&
         (rsp_data_ff.sum_mass_b == 64'sd0) && (rsp_data_ff.sum_mass_ab == 64'sd0))
      else $error("Nonzero sums on a beat that is not a read.");

endmodule

`default_nettype wire
